// File: hw/rtl/bpq_pkg.sv
// ============================================================================
// bpq_pkg
// Shared constants, codes and types of the bucket priority queue.
// ============================================================================
package bpq_pkg;

  localparam int LEVELS          = 16;
  localparam int PER_LEVEL_DEPTH = 16;
  localparam int VALUE_WIDTH     = 32;

  localparam int LVL_W   = $clog2(LEVELS);
  localparam int SLOT_W  = $clog2(PER_LEVEL_DEPTH);
  localparam int CNT_W   = $clog2(PER_LEVEL_DEPTH + 1);
  localparam int ADDR_W  = LVL_W + SLOT_W;
  localparam int STORE_DEPTH = LEVELS * PER_LEVEL_DEPTH;

  // Fixed field widths of the ports
  localparam int MODE_W   = 2;
  localparam int PRIO_W   = 4;
  localparam int TOTAL_W  = 9;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_ENQ   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Per-cell command from the controller
  typedef struct packed {
    logic enq;   // append at this level
    logic deq;   // broadcast: lowest non-empty level gives up its head
  } bpq_cell_ctrl_t;

  // Lowest non-empty level, rippled from level 0 upward
  typedef struct packed {
    logic              found;
    logic [LVL_W-1:0]  level;
    logic [SLOT_W-1:0] head;
  } bpq_chain_t;

  // Per-cell status toward the controller
  typedef struct packed {
    logic              full;
    logic [SLOT_W-1:0] tail;
  } bpq_cell_stat_t;

endpackage

// File: hw/rtl/bpq_if.sv
// ============================================================================
// bpq_req_if / bpq_rsp_if
// Valid/ready channels carrying requests into and results out of the queue.
// ============================================================================
interface bpq_req_if;
  import bpq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [MODE_W-1:0]      mode;
  logic [VALUE_WIDTH-1:0] value;
  logic [PRIO_W-1:0]      priority_req;

  modport source (output valid, output mode, output value, output priority_req,
                  input ready);
  modport sink   (input valid, input mode, input value, input priority_req,
                  output ready);
endinterface

interface bpq_rsp_if;
  import bpq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] removed_value;
  logic [VALUE_WIDTH-1:0] head_value;
  logic [PRIO_W-1:0]      head_priority;
  logic                   is_empty;
  logic [TOTAL_W-1:0]     total_count;
  logic [STATUS_W-1:0]    status;

  modport source (output valid, output removed_value, output head_value,
                  output head_priority, output is_empty, output total_count,
                  output status, input ready);
  modport sink   (input valid, input removed_value, input head_value,
                  input head_priority, input is_empty, input total_count,
                  input status, output ready);
endinterface

// File: hw/rtl/bpq_ram.sv
// ============================================================================
// bpq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module bpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/bpq_cell.sv
// ============================================================================
// bpq_cell
// One priority level: ring head and fill count, plus one link of the
// lowest-non-empty-level chain.
// ============================================================================
module bpq_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bpq_pkg::LVL_W-1:0]   lvl,
  input  bpq_pkg::bpq_cell_ctrl_t     ctrl,
  input  bpq_pkg::bpq_chain_t         chain_in,
  output bpq_pkg::bpq_chain_t         chain_out,
  output bpq_pkg::bpq_cell_stat_t     stat
);
  import bpq_pkg::*;

  logic [SLOT_W-1:0] head;
  logic [CNT_W-1:0]  count;
  logic              nonempty;
  logic              full;
  logic              take;

  assign nonempty = (count != '0);
  assign full     = (count == CNT_W'(PER_LEVEL_DEPTH));
  // Only the lowest non-empty level answers a dequeue
  assign take     = ctrl.deq && !chain_in.found && nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctrl.enq && !full) begin
      count <= count + 1'b1;
    end else if (take) begin
      head  <= head + 1'b1;
      count <= count - 1'b1;
    end
  end

  always_comb begin
    chain_out = chain_in;
    if (!chain_in.found && nonempty) begin
      chain_out.found = 1'b1;
      chain_out.level = lvl;
      chain_out.head  = head;
    end
  end

  assign stat.full = full;
  assign stat.tail = head + count[SLOT_W-1:0];

endmodule

// File: hw/rtl/bucket_priority_queue.sv
// ============================================================================
// bucket_priority_queue
// Priority queue with one FIFO per level; level 0 is served first.
// ============================================================================
//
//   port        direction  carries
//   ----------  ---------  ------------------------------------------------
//   req         in         mode, value, priority_req (valid/ready)
//   rsp         out        removed_value, head_value, head_priority,
//                          is_empty, total_count, status (valid/ready)
//   top_level_* in         write enable and data of the top_level register
//
// Each request goes through update of the level cells and the entry RAM (S_IDLE),
// then a registered RAM read of the new head (S_LOOK), then load of the result
// register (S_FETCH). The single read port of the entry RAM makes the two reads of a dequeue take turns.
// Reset clears the level cells and counters; the entry RAM needs no clear.
// A result waiting on rsp does not stop the next request from being taken;
// that request then waits in S_FETCH until the result register frees.

module bucket_priority_queue (
  input  logic                       clk,
  input  logic                       rst,
  bpq_req_if.sink                    req,
  bpq_rsp_if.source                  rsp,
  input  logic                       top_level_we,
  input  logic [bpq_pkg::PRIO_W-1:0] top_level_wdata
);
  import bpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_LOOK  = 3'b010,
    S_FETCH = 3'b100
  } state_t;

  state_t state, state_next;

  logic [PRIO_W-1:0]      top_level;
  logic [TOTAL_W-1:0]     entry_total;
  status_t                op_status;
  logic                   op_deq_ok;
  logic [VALUE_WIDTH-1:0] removed_hold;
  logic [PRIO_W-1:0]      head_prio_hold;
  logic                   empty_hold;

  logic                   out_valid;
  logic [VALUE_WIDTH-1:0] out_removed;
  logic [VALUE_WIDTH-1:0] out_head;
  logic [PRIO_W-1:0]      out_prio;
  logic                   out_empty;
  logic [TOTAL_W-1:0]     out_total;
  status_t                out_status;

  bpq_chain_t      chain [LEVELS+1];
  bpq_cell_ctrl_t  cell_ctrl [LEVELS];
  bpq_cell_stat_t  cell_stat [LEVELS];

  logic                   accept;
  logic                   is_enq;
  logic                   is_deq;
  logic                   range_bad;
  logic [LVL_W-1:0]       req_lvl;
  logic                   enq_go;
  logic                   deq_go;
  status_t                status_new;
  logic                   ram_re;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  logic                   out_load;

  // ---------------------------------------------------------------- decode
  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && !rst;
  assign is_enq    = (req.mode == MODE_ENQ);
  assign is_deq    = (req.mode == MODE_DEQ);
  assign req_lvl   = LVL_W'(req.priority_req);
  assign range_bad = (req.priority_req > top_level) ||
                     (32'(req.priority_req) >= LEVELS);
  assign enq_go    = accept && is_enq && !range_bad && !cell_stat[req_lvl].full;
  assign deq_go    = accept && is_deq && chain[LEVELS].found;

  always_comb begin
    status_new = ST_OK;
    if (is_enq) begin
      if (range_bad) begin
        status_new = ST_RANGE;
      end else if (cell_stat[req_lvl].full) begin
        status_new = ST_FULL;
      end
    end else if (is_deq && !chain[LEVELS].found) begin
      status_new = ST_EMPTY;
    end
  end

  // ---------------------------------------------------------------- cells
  assign chain[0] = '0;

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    assign cell_ctrl[i].enq = enq_go && (req_lvl == LVL_W'(i));
    assign cell_ctrl[i].deq = deq_go;

    bpq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .lvl       (LVL_W'(i)),
      .ctrl      (cell_ctrl[i]),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .stat      (cell_stat[i])
    );
  end

  // ---------------------------------------------------------------- entry RAM
  // Read the old head on a dequeue, then the new head in the following S_LOOK cycle
  assign ram_re = deq_go || (state == S_LOOK);

  bpq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (enq_go),
    .waddr ({req_lvl, cell_stat[req_lvl].tail}),
    .wdata (req.value),
    .re    (ram_re),
    .raddr ({chain[LEVELS].level, chain[LEVELS].head}),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- control
  assign out_load = (state == S_FETCH) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_LOOK;
      S_LOOK:  state_next = S_FETCH;
      S_FETCH: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      top_level   <= PRIO_W'(15);
      entry_total <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (top_level_we) begin
        top_level <= top_level_wdata;
      end
      if (enq_go) begin
        entry_total <= entry_total + 1'b1;
      end else if (deq_go) begin
        entry_total <= entry_total - 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_status <= status_new;
      op_deq_ok <= deq_go;
    end
    if (state == S_LOOK) begin
      // Hold the removed entry before the head read overwrites the RAM output
      removed_hold   <= op_deq_ok ? ram_rdata : '0;
      head_prio_hold <= chain[LEVELS].found ? PRIO_W'(chain[LEVELS].level) : '0;
      empty_hold     <= !chain[LEVELS].found;
    end
    if (out_load) begin
      out_removed <= removed_hold;
      out_head    <= empty_hold ? '0 : ram_rdata;
      out_prio    <= head_prio_hold;
      out_empty   <= empty_hold;
      out_total   <= entry_total;
      out_status  <= op_status;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.removed_value = out_removed;
  assign rsp.head_value    = out_head;
  assign rsp.head_priority = out_prio;
  assign rsp.is_empty      = out_empty;
  assign rsp.total_count   = out_total;
  assign rsp.status        = out_status;

`ifndef NO_ASSERTIONS
  a_total_matches_cells: assert property (@(posedge clk) disable iff (rst)
    (entry_total == '0) == !chain[LEVELS].found)
    else $error("entry count disagrees with level cells");

  a_look_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |-> $past(accept))
    else $error("head lookup without an accepted request");

  a_empty_means_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_empty) |-> (rsp.total_count == '0))
    else $error("empty result with nonzero count");
`endif

endmodule

// File: tb/tb.sv
// ============================================================================
// tb
// Self-checking bench for bucket_priority_queue. A directed opening covers an
// empty dequeue, the unused mode, extreme values and a full level. Random
// phases then run under several top_level settings, including lowered ones
// that strand stored entries. An in-bench queue model predicts every reply,
// and each reply is compared field by field in arrival order.
// ============================================================================
module tb;
  import bpq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 500;

  typedef struct packed {
    logic [MODE_W-1:0]      mode;
    logic [VALUE_WIDTH-1:0] value;
    logic [PRIO_W-1:0]      prio;
  } pq_op_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] removed_value;
    logic [VALUE_WIDTH-1:0] head_value;
    logic [PRIO_W-1:0]      head_priority;
    logic                   is_empty;
    logic [TOTAL_W-1:0]     total_count;
    status_t                status;
  } pq_reply_t;

  logic clk;
  logic rst;
  logic top_level_we;
  logic [PRIO_W-1:0] top_level_wdata;

  bpq_req_if req ();
  bpq_rsp_if rsp ();

  bucket_priority_queue dut (
    .clk             (clk),
    .rst             (rst),
    .req             (req),
    .rsp             (rsp),
    .top_level_we    (top_level_we),
    .top_level_wdata (top_level_wdata)
  );

  // Queue model
  logic [VALUE_WIDTH-1:0] lvl_store [LEVELS][PER_LEVEL_DEPTH];
  logic [SLOT_W-1:0]      lvl_head  [LEVELS];
  logic [CNT_W-1:0]       lvl_fill  [LEVELS];
  logic [TOTAL_W-1:0]     stored_total;
  logic [PRIO_W-1:0]      top_accepted;

  pq_op_t    op_queue[$];
  pq_reply_t reply_queue[$];

  int  mismatches = 0;
  int  ops_taken = 0;
  int  quiet_cycles = 0;
  bit  op_taken = 0;
  bit  idling_on = 1;
  int  src_idle = 0;
  int  sink_idle = 0;
  int  hold_left = 0;
  bit  hold_done = 0;

  function automatic int lowest_busy_level();
    for (int lv = 0; lv < LEVELS; lv++) begin
      if (lvl_fill[lv] != 0) return lv;
    end
    return LEVELS;
  endfunction

  function automatic pq_reply_t serve_request(pq_op_t op);
    pq_reply_t res;
    int        lv;
    int        slot;
    res = '0;
    res.status = ST_OK;
    if (op.mode == MODE_ENQ) begin
      if (op.prio > top_accepted) begin
        res.status = ST_RANGE;
      end else if (lvl_fill[op.prio] == PER_LEVEL_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        slot = (lvl_head[op.prio] + lvl_fill[op.prio]) % PER_LEVEL_DEPTH;
        lvl_store[op.prio][slot] = op.value;
        lvl_fill[op.prio] = lvl_fill[op.prio] + 1'b1;
        stored_total = stored_total + 1'b1;
      end
    end else if (op.mode == MODE_DEQ) begin
      lv = lowest_busy_level();
      if (lv == LEVELS) begin
        res.status = ST_EMPTY;
      end else begin
        res.removed_value = lvl_store[lv][lvl_head[lv]];
        lvl_head[lv] = lvl_head[lv] + 1'b1;
        lvl_fill[lv] = lvl_fill[lv] - 1'b1;
        stored_total = stored_total - 1'b1;
      end
    end
    // query and the unused mode leave the state alone
    lv = lowest_busy_level();
    if (lv < LEVELS) begin
      res.head_value    = lvl_store[lv][lvl_head[lv]];
      res.head_priority = lv[PRIO_W-1:0];
      res.is_empty      = 1'b0;
    end else begin
      res.is_empty = 1'b1;
    end
    res.total_count = stored_total;
    return res;
  endfunction

  function automatic pq_op_t random_op(int enq_pct, int deq_pct, logic [PRIO_W-1:0] top);
    pq_op_t op;
    int     pick;
    pick = $urandom_range(0, 99);
    if (pick < enq_pct) op.mode = MODE_ENQ;
    else if (pick < enq_pct + deq_pct) op.mode = MODE_DEQ;
    else if ($urandom_range(0, 1) == 0) op.mode = MODE_QUERY;
    else op.mode = MODE_SPARE;
    case ($urandom_range(0, 9))
      0:       op.value = '0;
      1:       op.value = '1;
      default: op.value = $urandom;
    endcase
    // mostly legal levels, some anywhere to hit the range check
    if ($urandom_range(0, 4) == 0) op.prio = $urandom_range(0, LEVELS - 1);
    else op.prio = $urandom_range(0, top);
    return op;
  endfunction

  task automatic push_op(input logic [MODE_W-1:0] mode, input logic [VALUE_WIDTH-1:0] value,
                         input logic [PRIO_W-1:0] prio);
    pq_op_t op;
    op.mode  = mode;
    op.value = value;
    op.prio  = prio;
    op_queue.push_back(op);
  endtask

  task automatic wait_drained();
    while (op_queue.size() != 0 || reply_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [PRIO_W-1:0] top, input int n_ops,
                           input int enq_pct, input int deq_pct);
    wait_drained();
    top_level_we    <= 1'b1;
    top_level_wdata <= top;
    top_accepted = top;
    @(negedge clk);
    top_level_we <= 1'b0;
    @(posedge clk);
    repeat (n_ops) op_queue.push_back(random_op(enq_pct, deq_pct, top));
  endtask

  task automatic check_field(input string name, input logic [VALUE_WIDTH-1:0] want,
                             input logic [VALUE_WIDTH-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Request driver: hold an offer until its transfer, then maybe idle
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && !op_taken) begin
      // hold the current offer
    end else if (src_idle > 0) begin
      src_idle--;
      req.valid <= 1'b0;
    end else if (op_queue.size() == 0) begin
      req.valid <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      src_idle = $urandom_range(1, 17) - 1;
      req.valid <= 1'b0;
    end else begin
      req.valid        <= 1'b1;
      req.mode         <= op_queue[0].mode;
      req.value        <= op_queue[0].value;
      req.priority_req <= op_queue[0].prio;
    end
  end

  // Reply sink: random stalls plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (!hold_done && ops_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else if (sink_idle > 0) begin
      sink_idle--;
      rsp.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      sink_idle = $urandom_range(1, 17) - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Monitor: predict on each request transfer, check each reply transfer
  always @(posedge clk) begin
    pq_op_t    op;
    pq_reply_t want;
    if (rst) begin
      op_taken = 1'b0;
    end else begin
      op_taken = req.valid && req.ready;
      if (op_taken) begin
        op.mode  = req.mode;
        op.value = req.value;
        op.prio  = req.priority_req;
        void'(op_queue.pop_front());
        reply_queue.push_back(serve_request(op));
        ops_taken++;
      end
      if (rsp.valid && rsp.ready) begin
        if (reply_queue.size() == 0) begin
          $display("%0t: unexpected reply: expected none, got head %h total %0d status %0d",
                   $time, rsp.head_value, rsp.total_count, rsp.status);
          mismatches++;
        end else begin
          want = reply_queue.pop_front();
          check_field("removed_value", want.removed_value, rsp.removed_value);
          check_field("head_value", want.head_value, rsp.head_value);
          check_field("head_priority", want.head_priority, rsp.head_priority);
          check_field("is_empty", want.is_empty, rsp.is_empty);
          check_field("total_count", want.total_count, rsp.total_count);
          check_field("status", want.status, rsp.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    top_level_we     = 1'b0;
    top_level_wdata  = '0;
    req.valid        = 1'b0;
    req.mode         = MODE_QUERY;
    req.value        = '0;
    req.priority_req = '0;
    rsp.ready        = 1'b0;
    for (int lv = 0; lv < LEVELS; lv++) begin
      lvl_head[lv] = '0;
      lvl_fill[lv] = '0;
    end
    stored_total = '0;
    top_accepted = 4'd15;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty queue, unused mode, extreme values, then one level filled past full
    push_op(MODE_DEQ, 32'h1234_5678, 4'd0);
    push_op(MODE_QUERY, '0, 4'd0);
    push_op(MODE_SPARE, '1, 4'd15);
    push_op(MODE_ENQ, '1, 4'd15);
    push_op(MODE_ENQ, '0, 4'd0);
    push_op(MODE_QUERY, '1, 4'd15);
    push_op(MODE_DEQ, '0, 4'd0);
    for (int i = 0; i < PER_LEVEL_DEPTH; i++) push_op(MODE_ENQ, 32'h9000_0000 + i, 4'd9);
    push_op(MODE_ENQ, 32'hDEAD_BEEF, 4'd9);
    push_op(MODE_DEQ, '0, 4'd0);

    run_phase(4'd15, 400, 90, 8);
    // lowered top level strands the upper entries; dequeues still drain them
    run_phase(4'd0, 350, 35, 55);
    run_phase(4'd7, 350, 45, 50);
    run_phase(4'($urandom_range(1, 14)), 350, 45, 50);
    wait_drained();
    idling_on = 1'b0;
    run_phase(4'd15, 350, 40, 55);

    wait_drained();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: bucket_priority_queue.f
hw/rtl/bpq_pkg.sv
hw/rtl/bpq_if.sv
hw/rtl/bpq_ram.sv
hw/rtl/bpq_cell.sv
hw/rtl/bucket_priority_queue.sv
tb/tb.sv
